@@ sv/sra_pkg.sv @@
// Package with the shared constants, types and ray tables of the sliding ray attack generator.
package sra_pkg;

	// Board geometry.
	localparam int BOARD_DIM = 8;
	localparam int BOARD_MAX = 7;
	localparam int SQ_W      = 6;
	localparam int COORD_W   = 3;
	localparam int BOARD_W   = BOARD_DIM * BOARD_DIM;

	// Rooks and bishops each walk four rays of at most seven squares each.
	localparam int RAY_CNT = 4;
	localparam int RAY_LEN = 7;

	// Piece kind codes; any other code gives an empty attack set.
	localparam logic [1:0] KIND_ROOK   = 2'd0;
	localparam logic [1:0] KIND_BISHOP = 2'd1;
	localparam logic [1:0] KIND_OTHER  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Signed coordinate wide enough for a square seven steps off the board.
	typedef logic signed [4:0] coord_t;
	typedef logic signed [1:0] delta_t;

	typedef logic [RAY_LEN-1:0]        ray_bits_t;
	typedef ray_bits_t [RAY_CNT-1:0]   ray_set_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef sq_t [RAY_LEN-1:0]         ray_idx_t;
	typedef ray_idx_t [RAY_CNT-1:0]    ray_idx_set_t;

	// Rank and file steps of the orthogonal rays: north, south, east, west.
	localparam delta_t ROOK_DR [RAY_CNT] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0};
	localparam delta_t ROOK_DF [RAY_CNT] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1};

	// Rank and file steps of the diagonal rays.
	localparam delta_t BISHOP_DR [RAY_CNT] = '{2'sd1, -2'sd1, 2'sd1, -2'sd1};
	localparam delta_t BISHOP_DF [RAY_CNT] = '{2'sd1, 2'sd1, -2'sd1, -2'sd1};

endpackage

@@ sv/sliding_ray_attack_generator.sv @@
// Pipelined attack set generator for rooks and bishops on a 64-square bitboard.
//
//   channel | handshake           | fields
//   --------+---------------------+------------------------------------------
//   in      | in_valid, in_stall  | action, origin_square, occupied_board
//   out     | out_valid, out_stall| attack_board
//
// One word enters per cycle while in_stall is low; each result word is registered
// behind four register stages (input register, ray gather,
// ray scan, scatter to the board).
// A reset clears only the valid bits of the four stages.
// A stalled output holds its word; each stage still loads while the stage
// after it is empty, so bubbles are squeezed out before the input stalls.
module sliding_ray_attack_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [5:0]  origin_square,
	input  logic [63:0] occupied_board,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] attack_board
);

	// Stage registers.
	logic                              v_s1, v_s2, v_s3, v_s4;
	logic [1:0]                        kind_s1;
	logic [sra_pkg::COORD_W-1:0]       rank_s1, file_s1;
	logic [sra_pkg::BOARD_W-1:0]       blk_s1;
	sra_pkg::ray_set_t                 on_s2, occ_s2;
	sra_pkg::ray_idx_set_t             idx_s2, idx_s3;
	sra_pkg::ray_set_t                 reach_s3;
	logic [sra_pkg::BOARD_W-1:0]       attack_s4;

	logic en1, en2, en3, en4;

	// A stage loads when it is empty or when its word moves on.
	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: register the word; the origin never acts as a blocker.
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			kind_s1 <= action;
			rank_s1 <= origin_square[5:3];
			file_s1 <= origin_square[2:0];
			blk_s1  <= occupied_board & ~(64'd1 << origin_square);
		end
	end

	// Stage 2 logic: list the squares of each ray with their on-board and occupancy bits.
	sra_pkg::ray_set_t     on_d, occ_d;
	sra_pkg::ray_idx_set_t idx_d;

	always_comb begin
		sra_pkg::delta_t dr;
		sra_pkg::delta_t df;
		sra_pkg::coord_t rr;
		sra_pkg::coord_t ff;
		logic            kind_ok;
		kind_ok = (kind_s1 == sra_pkg::KIND_ROOK) || (kind_s1 == sra_pkg::KIND_BISHOP);
		on_d  = '0;
		occ_d = '0;
		idx_d = '0;
		for (int r = 0; r < sra_pkg::RAY_CNT; r++) begin
			dr = (kind_s1 == sra_pkg::KIND_ROOK) ? sra_pkg::ROOK_DR[r] : sra_pkg::BISHOP_DR[r];
			df = (kind_s1 == sra_pkg::KIND_ROOK) ? sra_pkg::ROOK_DF[r] : sra_pkg::BISHOP_DF[r];
			rr = $signed({2'b00, rank_s1});
			ff = $signed({2'b00, file_s1});
			for (int k = 0; k < sra_pkg::RAY_LEN; k++) begin
				// Step one square further along the ray.
				rr = rr + sra_pkg::coord_t'(dr);
				ff = ff + sra_pkg::coord_t'(df);
				idx_d[r][k] = {rr[2:0], ff[2:0]};
				on_d[r][k]  = kind_ok && (rr >= 5'sd0) && (rr <= 5'sd7) &&
				              (ff >= 5'sd0) && (ff <= 5'sd7);
				occ_d[r][k] = blk_s1[idx_d[r][k]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			on_s2  <= on_d;
			occ_s2 <= occ_d;
			idx_s2 <= idx_d;
		end
	end

	// Stage 3 logic: a square is reached while no earlier square of its ray is occupied.
	sra_pkg::ray_set_t reach_d;

	always_comb begin
		logic open_ray;
		reach_d = '0;
		for (int r = 0; r < sra_pkg::RAY_CNT; r++) begin
			open_ray = 1'b1;
			for (int k = 0; k < sra_pkg::RAY_LEN; k++) begin
				reach_d[r][k] = on_s2[r][k] && open_ray;
				open_ray      = open_ray && !occ_s2[r][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			reach_s3 <= reach_d;
			idx_s3   <= idx_s2;
		end
	end

	// Stage 4 logic: scatter the reached squares back onto the board.
	logic [sra_pkg::BOARD_W-1:0] attack_d;

	always_comb begin
		attack_d = '0;
		for (int r = 0; r < sra_pkg::RAY_CNT; r++) begin
			for (int k = 0; k < sra_pkg::RAY_LEN; k++) begin
				if (reach_s3[r][k]) begin
					attack_d[idx_s3[r][k]] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			attack_s4 <= attack_d;
		end
	end

	assign out_valid    = v_s4;
	assign attack_board = attack_s4;

endmodule

@@ tb/sra_checker.sv @@
// Checker that predicts and compares every attack set of the sliding ray attack generator.
`timescale 1ns / 100ps

module sra_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [5:0]  origin_square,
	input  logic [63:0] occupied_board,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] attack_board,
	output int          mismatch_total,
	output int          pending_results
);

	// One accepted query together with the attack set it should produce.
	typedef struct {
		logic [1:0]  kind;
		logic [5:0]  square;
		logic [63:0] occupancy;
		logic [63:0] attacks;
	} attack_query_t;

	attack_query_t pending_attacks[$];

	// Walks the four rays of the piece from the origin, stopping on the first blocker.
	function automatic logic [63:0] predict_attacks(logic [1:0] kind, logic [5:0] square,
			logic [63:0] occupancy);
		logic [63:0] blockers;
		logic [63:0] reach;
		int          rank;
		int          file;
		int          dr;
		int          df;
		int          r;
		int          f;
		bit          blocked;
		reach = '0;
		// The origin never blocks, even when its bit is set.
		blockers = occupancy;
		blockers[square] = 1'b0;
		rank = square / sra_pkg::BOARD_DIM;
		file = square % sra_pkg::BOARD_DIM;
		if (kind != sra_pkg::KIND_ROOK && kind != sra_pkg::KIND_BISHOP)
			return '0;
		for (int d = 0; d < sra_pkg::RAY_CNT; d++) begin
			if (kind == sra_pkg::KIND_ROOK) begin
				unique case (d)
					0: begin dr = 1;  df = 0;  end
					1: begin dr = -1; df = 0;  end
					2: begin dr = 0;  df = 1;  end
					default: begin dr = 0; df = -1; end
				endcase
			end else begin
				dr = (d % 2 == 0) ? 1 : -1;
				df = (d < 2) ? 1 : -1;
			end
			r = rank + dr;
			f = file + df;
			blocked = 1'b0;
			while (!blocked && r >= 0 && r <= sra_pkg::BOARD_MAX &&
					f >= 0 && f <= sra_pkg::BOARD_MAX) begin
				reach[r * sra_pkg::BOARD_DIM + f] = 1'b1;
				if (blockers[r * sra_pkg::BOARD_DIM + f])
					blocked = 1'b1;
				r = r + dr;
				f = f + df;
			end
		end
		return reach;
	endfunction

	// Record each accepted query word and check each accepted result word against the oldest.
	always @(posedge clk) begin : watch
		attack_query_t q;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				q.kind      = action;
				q.square    = origin_square;
				q.occupancy = occupied_board;
				q.attacks   = predict_attacks(action, origin_square, occupied_board);
				pending_attacks.push_back(q);
			end
			if (out_valid && !out_stall) begin
				if (pending_attacks.size() == 0) begin
					if (mismatch_total < 10)
						$display("unexpected result word: attack_board %h", attack_board);
					mismatch_total++;
				end else begin
					q = pending_attacks.pop_front();
					if (attack_board !== q.attacks) begin
						if (mismatch_total < 10)
							$display("mismatch: kind %0d sq %0d occ %h: exp %h got %h",
								q.kind, q.square, q.occupancy, q.attacks,
								attack_board);
						mismatch_total++;
					end
				end
			end
		end
		pending_results = pending_attacks.size();
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the testbench: clock, reset, query stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps

module tb_top;

	localparam int    RANDOM_PER_PHASE = 550;
	localparam int    HOLD_CYCLES      = 300;
	localparam int    DRAIN_CYCLES     = 12;
	localparam time   RUN_LIMIT        = 10_000_000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [5:0]  origin_square;
	logic [63:0] occupied_board;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] attack_board;

	int mismatch_total;
	int pending_results;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_go;
	bit hold_done;

	sliding_ray_attack_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.origin_square (origin_square),
		.occupied_board(occupied_board),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.attack_board  (attack_board)
	);

	sra_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.origin_square  (origin_square),
		.occupied_board (occupied_board),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.attack_board   (attack_board),
		.mismatch_total (mismatch_total),
		.pending_results(pending_results)
	);

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = sra_pkg::KIND_ROOK;
		origin_square  = '0;
		occupied_board = '0;
		out_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go        = 1'b0;
		hold_done      = 1'b0;
	end

	always #10 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#(RUN_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so that the pipeline backs up.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Offers one query word after a random gap and waits until it is taken.
	task automatic send_query(logic [1:0] kind, logic [5:0] square, logic [63:0] occupancy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		action         <= kind;
		origin_square  <= square;
		occupied_board <= occupancy;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Occupancy boards of mixed density, from nearly empty to nearly full.
	function automatic logic [63:0] random_board();
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		unique case ($urandom_range(0, 3))
			0: return a & b;
			1: return a | b;
			2: return a;
			default: return a & b & c;
		endcase
	endfunction

	function automatic logic [1:0] random_kind();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return sra_pkg::KIND_ROOK;
		else if (pick < 8)
			return sra_pkg::KIND_BISHOP;
		else if (pick == 8)
			return sra_pkg::KIND_OTHER;
		else
			return sra_pkg::KIND_UNUSED;
	endfunction

	initial begin : stimulus
		logic [5:0] sq;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 10;
		recv_stall_pct = 82;

		// Corners and one interior square on an empty board.
		send_query(sra_pkg::KIND_ROOK,   6'd0,  64'h0);
		send_query(sra_pkg::KIND_ROOK,   6'd63, 64'h0);
		send_query(sra_pkg::KIND_BISHOP, 6'd0,  64'h0);
		send_query(sra_pkg::KIND_BISHOP, 6'd63, 64'h0);
		send_query(sra_pkg::KIND_BISHOP, 6'd7,  64'h0);
		send_query(sra_pkg::KIND_BISHOP, 6'd56, 64'h0);
		send_query(sra_pkg::KIND_ROOK,   6'd35, 64'h0);
		// Full board: only the neighbors are reached, and the occupied origin is ignored.
		send_query(sra_pkg::KIND_ROOK,   6'd27, '1);
		send_query(sra_pkg::KIND_BISHOP, 6'd36, '1);
		send_query(sra_pkg::KIND_ROOK,   6'd63, '1);
		send_query(sra_pkg::KIND_BISHOP, 6'd0,  '1);
		// Only the origin occupied: rays run to the edges.
		send_query(sra_pkg::KIND_ROOK,   6'd19, 64'h1 << 19);
		send_query(sra_pkg::KIND_BISHOP, 6'd44, 64'h1 << 44);
		// Blockers on the far edge, then alternating patterns.
		send_query(sra_pkg::KIND_ROOK,   6'd0,  64'h8000_0000_0000_0080);
		send_query(sra_pkg::KIND_ROOK,   6'd28, 64'hAAAA_AAAA_AAAA_AAAA);
		send_query(sra_pkg::KIND_BISHOP, 6'd21, 64'h5555_5555_5555_5555);
		send_query(sra_pkg::KIND_BISHOP, 6'd42, 64'hFF00_FF00_FF00_FF00);
		// Other piece kinds give an empty set.
		send_query(sra_pkg::KIND_OTHER,  6'd27, '1);
		send_query(sra_pkg::KIND_UNUSED, 6'd63, 64'h0123_4567_89AB_CDEF);
		send_query(sra_pkg::KIND_UNUSED, 6'd0,  64'h0);

		// Random queries in three idling regimes; the long hold-off opens the first one.
		for (int ph = 0; ph < 3; ph++) begin
			unique case (ph)
				0: begin send_idle_pct = 10; recv_stall_pct = 82; hold_go = 1'b1; end
				1: begin send_idle_pct = 82; recv_stall_pct = 10; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				sq = 6'($urandom_range(0, 63));
				send_query(random_kind(), sq, random_board());
			end
		end
		in_valid <= 1'b0;

		// Drain, then allow for the pipeline depth before the verdict.
		@(posedge clk);
		wait (pending_results == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_total == 0 && pending_results == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/sra_pkg.sv
sv/sliding_ray_attack_generator.sv
tb/sra_checker.sv
tb/tb_top.sv
